[hdl/symbol_counter_extension_macros.svh]
// ----------------------------------------------------------------------------
// symbol_counter_extension_macros.svh
// Assertion macros used by the timer extension RTL.
// ----------------------------------------------------------------------------
`ifndef SYMBOL_COUNTER_EXTENSION_MACROS_SVH
`define SYMBOL_COUNTER_EXTENSION_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define SCE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sce assertion failed");
// Next-cycle implication, checked out of reset.
`define SCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sce assertion failed");
`else
`define SCE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SCE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hdl/sce_pkg.sv]
// ----------------------------------------------------------------------------
// sce_pkg
// Types and constants for the 16-to-32-bit timer extension.
// ----------------------------------------------------------------------------
package sce_pkg;

    // Mode codes
    localparam logic MODE_SERVICE = 1'b0;
    localparam logic MODE_READ    = 1'b1;

    // Low words at or above this mark belong before a same-event wrap
    localparam logic [15:0] HALF_MARK = 16'h8000;
    // One full turn of the low counter
    localparam logic [31:0] LOW_TURN  = 32'h0001_0000;

    typedef struct packed {
        logic        mode;
        logic        overflow_flag;
        logic        compare_flag;
        logic        capture_flag;
        logic        overcapture_flag;
        logic [15:0] capture_low;
        logic [15:0] counter_low;
    } evt_t;

    typedef struct packed {
        logic        compare_match;
        logic [31:0] last_capture;
        logic        capture_valid;
        logic [31:0] current_value;
    } res_t;

    // Pipeline control between the input stage and the core
    typedef struct packed {
        logic fire;
        logic mode;
    } pipe_ctl_t;

endpackage

[hdl/sce_if.sv]
// ----------------------------------------------------------------------------
// sce_if
// Valid/ready channels: timer events, results and compare configuration.
// ----------------------------------------------------------------------------
interface sce_evt_if;
    logic          valid;
    logic          ready;
    sce_pkg::evt_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sce_res_if;
    logic          valid;
    logic          ready;
    sce_pkg::res_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sce_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/sce_in_reg.sv]
// ----------------------------------------------------------------------------
// sce_in_reg
// Input register: holds one event request until the core consumes it.
// ----------------------------------------------------------------------------
module sce_in_reg (
    input  logic          clk,
    input  logic          rst_n,
    sce_evt_if.sink       evt,
    input  logic          adv,
    output logic          vld,
    output sce_pkg::evt_t item
);
    import sce_pkg::*;

    logic vld_reg;
    logic vld_next;
    evt_t item_reg;
    logic take;

    // Accept when empty or when the held request moves on
    assign evt.ready = !vld_reg || adv;
    assign take      = evt.valid && evt.ready;
    assign vld_next  = evt.ready ? evt.valid : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= evt.data;
        end
    end

    assign vld  = vld_reg;
    assign item = item_reg;

endmodule

[hdl/sce_core.sv]
// ----------------------------------------------------------------------------
// sce_core
// Extension state, compare register and the per-event update logic.
// ----------------------------------------------------------------------------
`include "symbol_counter_extension_macros.svh"

module sce_core (
    input  logic               clk,
    input  logic               rst_n,
    input  sce_pkg::pipe_ctl_t ctl,
    input  sce_pkg::evt_t      item,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_data,
    output sce_pkg::res_t      result
);
    import sce_pkg::*;

    logic [31:0] compare_reg;
    logic [15:0] high_half_reg;
    logic [15:0] high_half_next;
    logic [31:0] capture_time_reg;
    logic [31:0] capture_time_next;
    logic        capture_ok_reg;
    logic        capture_ok_next;

    logic        service;
    logic [15:0] hi_inc;
    logic [15:0] hi_cmp;
    logic [15:0] hi_cap;
    logic        match;
    logic [31:0] now;

    logic        fire_ovf;
    logic        fire_ocap;
    logic        fire_read;
    logic [48:0] ext_state;

    assign service = (ctl.mode == MODE_SERVICE);

    always_comb
    begin
        // Count a pending overflow, then step back for low words before the wrap
        hi_inc = high_half_reg + {15'd0, item.overflow_flag};
        hi_cmp = hi_inc - {15'd0, item.overflow_flag && (compare_reg[15:0] >= HALF_MARK)};
        hi_cap = hi_inc - {15'd0, item.overflow_flag && (item.capture_low >= HALF_MARK)};
        match  = item.compare_flag && (hi_cmp == compare_reg[31:16]);

        high_half_next    = high_half_reg;
        capture_time_next = capture_time_reg;
        capture_ok_next   = capture_ok_reg;
        now               = 32'd0;

        if (service)
        begin
            high_half_next = hi_inc;
            if (item.overcapture_flag)
            begin
                capture_ok_next = 1'b0;
            end
            else if (item.capture_flag)
            begin
                capture_time_next = {hi_cap, item.capture_low};
                capture_ok_next   = 1'b1;
            end
        end
        else
        begin
            now = {high_half_reg, item.counter_low}
                + (item.overflow_flag ? LOW_TURN : 32'd0);
        end

        result.compare_match = service && match;
        result.last_capture  = capture_time_next;
        result.capture_valid = capture_ok_next;
        result.current_value = now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compare_reg      <= 32'd0;
            high_half_reg    <= 16'd0;
            capture_time_reg <= 32'd0;
            capture_ok_reg   <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                compare_reg <= cfg_data;
            end
            if (ctl.fire)
            begin
                high_half_reg    <= high_half_next;
                capture_time_reg <= capture_time_next;
                capture_ok_reg   <= capture_ok_next;
            end
        end
    end

    assign fire_ovf  = ctl.fire && service && item.overflow_flag;
    assign fire_ocap = ctl.fire && service && item.overcapture_flag;
    assign fire_read = ctl.fire && !service;
    assign ext_state = {high_half_reg, capture_time_reg, capture_ok_reg};

    `SCE_ASSERT_NEXT(a_hi_inc, clk, rst_n, fire_ovf, high_half_reg == $past(high_half_reg) + 16'd1)
    `SCE_ASSERT_NEXT(a_read_keeps, clk, rst_n, fire_read, $stable(ext_state))
    `SCE_ASSERT_NEXT(a_ocap_clr, clk, rst_n, fire_ocap, !capture_ok_reg && $stable(capture_time_reg))
    `SCE_ASSERT_NOW(a_read_no_match, clk, rst_n, !service, !result.compare_match)

endmodule

[hdl/sce_out_reg.sv]
// ----------------------------------------------------------------------------
// sce_out_reg
// Result register: holds one result request until the sink takes it.
// ----------------------------------------------------------------------------
module sce_out_reg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  sce_pkg::res_t result,
    output logic          adv,
    sce_res_if.source     res
);
    import sce_pkg::*;

    logic vld_reg;
    logic vld_next;
    res_t data_reg;

    // Advance when empty or when the held result is taken
    assign adv      = !vld_reg || res.ready;
    assign vld_next = adv ? load : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && load)
        begin
            data_reg <= result;
        end
    end

    assign res.valid = vld_reg;
    assign res.data  = data_reg;

endmodule

[hdl/symbol_counter_extension.sv]
// An accepted event request waits in the input register; the core update
//   logic forms its result, which is loaded into the result register.
// Throughput: one event per cycle while the result register is not stalled.
// Reset (rst_n low, asynchronous): both stages empty, high half and last
//   capture zero, capture valid one, compare value zero.
// ----------------------------------------------------------------------------
// symbol_counter_extension
// Widens a 16-bit timer to 32 bits with overflow servicing, compare match,
// capture extension and time reads.
// ----------------------------------------------------------------------------
module symbol_counter_extension (
    input  logic      clk,
    input  logic      rst_n,
    sce_evt_if.sink   evt,
    sce_res_if.source res,
    sce_cfg_if.sink   cfg
);
    import sce_pkg::*;

    logic      in_vld;
    evt_t      in_item;
    logic      out_adv;
    pipe_ctl_t ctl;
    res_t      core_res;

    // Take configuration writes at once; the source must write only while
    // no event request is in flight, which the block itself does not enforce.
    assign cfg.ready = 1'b1;

    // Hold the next event request in the input register
    sce_in_reg u_in (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt),
        .adv   (out_adv),
        .vld   (in_vld),
        .item  (in_item)
    );

    // The held event updates state in the same cycle it moves into the
    // result register, so the next event sees the updated high half.
    assign ctl.fire = in_vld && out_adv;
    assign ctl.mode = in_item.mode;

    sce_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .item     (in_item),
        .cfg_we   (cfg.valid && cfg.ready),
        .cfg_data (cfg.data),
        .result   (core_res)
    );

    // Drain results; a waiting result does not block the input side
    // as long as the result register is being emptied.
    sce_out_reg u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (in_vld),
        .result (core_res),
        .adv    (out_adv),
        .res    (res)
    );

endmodule

[bench/tb_symbol_counter_extension.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_symbol_counter_extension
// Self-checking bench for the 16-to-32-bit timer extension. Each accepted
// event request is run through an in-bench model of the extension, and the
// predicted result is queued. Every result request is checked field by field
// against the oldest prediction. Stimulus is a directed set, a run of
// overflows, random traffic under several idle and stall mixes, a long
// output hold-off and a mid-stream drain.
// ----------------------------------------------------------------------------
module tb_symbol_counter_extension;

    import sce_pkg::*;

    // Margin past the event-to-result path, used by the drain waits
    localparam int PIPE_LATENCY   = 2;
    // Idle cycles allowed with no request moving on any channel
    localparam int STALL_LIMIT    = 4000;
    // Length of the long output hold-off
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_REQUESTS = 190;
    // Overflow events in the run test
    localparam int RUN_STEPS      = 64;

    logic clk = 1'b0;
    logic rst_n;

    sce_evt_if evt_ch ();
    sce_res_if res_ch ();
    sce_cfg_if cfg_ch ();

    symbol_counter_extension uut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Model of the extension: high half, last capture and its valid mark,
    // plus the compare register. All follow the reset values.
    // ------------------------------------------------------------------
    logic [15:0] hi_word   = 16'h0000;
    logic [31:0] cap_stamp = 32'h0000_0000;
    logic        cap_good  = 1'b1;
    logic [31:0] cmp_word  = 32'h0000_0000;

    // Predicted results, oldest first
    res_t extension_results [$];

    int mismatch_count = 0;

    // Traffic shaping, in percent of cycles
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // Bumped by a test to start a long output hold-off
    int hold_starts    = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    // Work out the result of one event and advance the model state.
    function automatic res_t extend_event(input evt_t e);
        res_t        r;
        logic [15:0] h;
        r = '0;
        if (e.mode == MODE_SERVICE)
        begin
            // Count the pending wrap first; the corrections below see the new value
            if (e.overflow_flag)
                hi_word = hi_word + 16'd1;
            if (e.compare_flag)
            begin
                h = hi_word;
                // Compare word in the upper half of the low range belongs before the wrap
                if (e.overflow_flag && cmp_word[15:0] >= HALF_MARK)
                    h = h - 16'd1;
                r.compare_match = (h == cmp_word[31:16]);
            end
            // Overcapture wins over any capture in the same event
            if (e.overcapture_flag)
            begin
                cap_good = 1'b0;
            end
            else if (e.capture_flag)
            begin
                h = hi_word;
                if (e.overflow_flag && e.capture_low >= HALF_MARK)
                    h = h - 16'd1;
                cap_stamp = {h, e.capture_low};
                cap_good  = 1'b1;
            end
        end
        else
        begin
            // Time read: join the live low word, add a turn for an unserviced wrap
            r.current_value = {hi_word, e.counter_low};
            if (e.overflow_flag)
                r.current_value = r.current_value + LOW_TURN;
        end
        r.last_capture  = cap_stamp;
        r.capture_valid = cap_good;
        return r;
    endfunction

    function automatic evt_t mk_event(input logic mode, input logic ovf, input logic cmp,
                                      input logic cap, input logic ocap,
                                      input logic [15:0] cap_lo, input logic [15:0] cnt_lo);
        evt_t e;
        e.mode             = mode;
        e.overflow_flag    = ovf;
        e.compare_flag     = cmp;
        e.capture_flag     = cap;
        e.overcapture_flag = ocap;
        e.capture_low      = cap_lo;
        e.counter_low      = cnt_lo;
        return e;
    endfunction

    // Low words lean toward the edges of the correction mark.
    function automatic logic [15:0] pick_word();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return HALF_MARK - 16'd1;
            3:       return HALF_MARK;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic evt_t random_event();
        evt_t e;
        e.mode             = ($urandom_range(3) == 0) ? MODE_READ : MODE_SERVICE;
        e.overflow_flag    = 1'($urandom_range(1));
        e.compare_flag     = 1'($urandom_range(1));
        e.capture_flag     = 1'($urandom_range(1));
        e.overcapture_flag = ($urandom_range(4) == 0);
        e.capture_low      = pick_word();
        e.counter_low      = pick_word();
        return e;
    endfunction

    // ------------------------------------------------------------------
    // Send one event request; the prediction is queued at acceptance.
    // valid is left high on return so back-to-back requests need no toggle.
    // ------------------------------------------------------------------
    task automatic send_event(input evt_t e);
        res_t r;
        // Insert sender idle cycles at random
        while ($urandom_range(99) < send_idle_pct)
        begin
            evt_ch.valid <= 1'b0;
            @(posedge clk);
        end
        evt_ch.valid <= 1'b1;
        evt_ch.data  <= e;
        @(posedge clk);
        while (!evt_ch.ready)
            @(posedge clk);
        r = extend_event(e);
        extension_results.push_back(r);
    endtask

    // Drop valid and hold until every predicted result has been seen.
    task automatic drain_results();
        evt_ch.valid <= 1'b0;
        while (extension_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    // Write the compare register; only call with the block drained.
    task automatic write_compare(input logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        cmp_word = value;
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls, or a long hold-off when a test asks.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_starts != hold_seen)
        begin
            hold_seen = hold_starts;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each result request with the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (extension_results.size() == 0)
            begin
                $error("result request with no prediction outstanding");
                mismatch_count++;
            end
            else
            begin
                want = extension_results.pop_front();
                if (res_ch.data.compare_match !== want.compare_match)
                begin
                    $error("compare_match: expected %0d, actual %0d",
                           want.compare_match, res_ch.data.compare_match);
                    mismatch_count++;
                end
                if (res_ch.data.last_capture !== want.last_capture)
                begin
                    $error("last_capture: expected %08h, actual %08h",
                           want.last_capture, res_ch.data.last_capture);
                    mismatch_count++;
                end
                if (res_ch.data.capture_valid !== want.capture_valid)
                begin
                    $error("capture_valid: expected %0d, actual %0d",
                           want.capture_valid, res_ch.data.capture_valid);
                    mismatch_count++;
                end
                if (res_ch.data.current_value !== want.current_value)
                begin
                    $error("current_value: expected %08h, actual %08h",
                           want.current_value, res_ch.data.current_value);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when no request moves for too long.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, both modes and each corner of the correction logic.
    task automatic test_directed();
        // Reads at reset: plain, with a pending wrap, with ignored flags set
        send_event(mk_event(MODE_READ,    0, 0, 0, 0, 16'h0000, 16'h0000));
        send_event(mk_event(MODE_READ,    1, 0, 0, 0, 16'h0000, 16'hFFFF));
        send_event(mk_event(MODE_READ,    1, 1, 1, 1, 16'hFFFF, 16'h8000));
        // Empty service, then compare at reset value matches
        send_event(mk_event(MODE_SERVICE, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF));
        send_event(mk_event(MODE_SERVICE, 0, 1, 0, 0, 16'h0000, 16'h0000));
        // Wrap with compare: low compare word below the mark, no correction
        send_event(mk_event(MODE_SERVICE, 1, 1, 0, 0, 16'h0000, 16'h0000));
        // Captures: plain, corrected at the mark, just under the mark
        send_event(mk_event(MODE_SERVICE, 0, 0, 1, 0, 16'h1234, 16'h0000));
        send_event(mk_event(MODE_SERVICE, 1, 0, 1, 0, HALF_MARK, 16'h0000));
        send_event(mk_event(MODE_SERVICE, 1, 0, 1, 0, HALF_MARK - 16'd1, 16'h0000));
        // Overcapture drops a same-event capture, then a lone overcapture
        send_event(mk_event(MODE_SERVICE, 0, 0, 1, 1, 16'hABCD, 16'h0000));
        send_event(mk_event(MODE_SERVICE, 0, 0, 0, 1, 16'h0000, 16'h0000));
        // Good capture restores the mark
        send_event(mk_event(MODE_SERVICE, 0, 0, 1, 0, 16'hFFFF, 16'h0000));
        // Every flag at once
        send_event(mk_event(MODE_SERVICE, 1, 1, 1, 1, 16'hFFFF, 16'hFFFF));
        send_event(mk_event(MODE_READ,    0, 0, 0, 0, 16'h0000, 16'h8000));

        // Aim the compare at the current high half with a low word above the mark:
        // a wrap in the same event corrects back onto it and matches
        drain_results();
        write_compare({hi_word, 16'h9000});
        send_event(mk_event(MODE_SERVICE, 1, 1, 0, 0, 16'h0000, 16'h0000));
        send_event(mk_event(MODE_SERVICE, 0, 1, 0, 0, 16'h0000, 16'h0000));
        send_event(mk_event(MODE_SERVICE, 1, 1, 1, 0, 16'hFFFF, 16'h0000));
        send_event(mk_event(MODE_READ,    1, 0, 0, 0, 16'h0000, 16'hFFFF));
        drain_results();
    endtask

    // Advance the high half through a run of back-to-back overflows, then
    // read the time and hit the compare on both sides of the mark.
    task automatic test_overflow_run();
        evt_t e;
        // Compare aimed at the high half reached after the run
        write_compare({hi_word + 16'(RUN_STEPS), HALF_MARK});
        repeat (RUN_STEPS)
        begin
            e = random_event();
            e.mode          = MODE_SERVICE;
            e.overflow_flag = 1'b1;
            send_event(e);
        end
        // Reads with and without a pending wrap
        send_event(mk_event(MODE_READ,    1, 0, 0, 0, 16'h0000, 16'h1234));
        send_event(mk_event(MODE_READ,    0, 0, 0, 0, 16'h0000, 16'hFFFF));
        send_event(mk_event(MODE_SERVICE, 0, 1, 0, 0, 16'h0000, 16'h0000));
        // Wrap with compare word at the mark: corrected half still matches
        send_event(mk_event(MODE_SERVICE, 1, 1, 1, 0, HALF_MARK, 16'h0000));
        send_event(mk_event(MODE_SERVICE, 1, 1, 1, 0, HALF_MARK - 16'd1, 16'h0000));
        drain_results();
    endtask

    // Random traffic under each idle and stall mix; the compare register changes per phase.
    task automatic test_random_traffic();
        int idle_mix  [4] = '{0, 47, 0, 21};
        int stall_mix [4] = '{0, 0, 47, 21};
        for (int p = 0; p < 4; p++)
        begin
            drain_results();
            if (p == 0)
                write_compare(32'hFFFF_FFFF);
            else
                write_compare({hi_word + 16'($urandom_range(2)), pick_word()});
            send_idle_pct  = idle_mix[p];
            recv_stall_pct = stall_mix[p];
            repeat (PHASE_REQUESTS) send_event(random_event());
        end
        drain_results();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // Hold the output off for a long stretch while requests keep coming,
    // so the block fills and stalls its input.
    task automatic test_output_backpressure();
        write_compare(32'h0000_0000);
        hold_starts = hold_starts + 1;
        repeat (40) send_event(random_event());
        drain_results();
    endtask

    // Pause the sender mid-stream until every result has come back.
    task automatic test_drain_pause();
        write_compare({hi_word, HALF_MARK});
        send_idle_pct  = 21;
        recv_stall_pct = 21;
        repeat (20) send_event(random_event());
        drain_results();
        repeat (20) send_event(random_event());
        drain_results();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        evt_ch.valid = 1'b0;
        evt_ch.data  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_overflow_run();
        test_random_traffic();
        test_output_backpressure();
        test_drain_pause();

        // Let the pipe settle past the last result
        drain_results();
        repeat (PIPE_LATENCY + 4) @(posedge clk);

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/sce_pkg.sv
hdl/sce_if.sv
hdl/sce_in_reg.sv
hdl/sce_core.sv
hdl/sce_out_reg.sv
hdl/symbol_counter_extension.sv
bench/tb_symbol_counter_extension.sv
